FILE: sv/lifo_pkg.sv
package lifo_pkg;

  // Stack depth and the widths that follow from it.
  localparam int DEPTH   = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Fixed field widths of the item formats.
  localparam int OP_W     = 3;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Common width for comparing the fill count against a position or a count field.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_CHANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic        [OP_W-1:0]   op;
    logic signed [WORD_W-1:0] value;
    logic        [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [WORD_W-1:0]   data;
    logic        [COUNT_W-1:0]  count;
    logic                       last;
  } out_item_t;

endpackage

FILE: sv/lifo_stack_engine.sv
// LIFO stack of signed 32-bit words held in a single-port-write, one-read
// synchronous memory of lifo_pkg::DEPTH entries (16 by default).
//
// Input channel (in_valid/in_ready/in_item) carries one operation per item:
// push, pop, peek, change (position counted from the top, 1 is the top) or
// dump. Op codes above dump are dropped without a result or a state change.
// Result channel (out_valid/out_ready/out_item) returns status, data, the
// fill count after the operation and a last flag on the final result.
//
// Sequencing: push, change and any rejected operation go from accept through
// emit to the output register; pop and peek pass through the read state first,
// because the memory read is registered. Dump walks the memory from the bottom
// entry up through the dump read and emit states, one held entry at a time. The
// sequencer handles one item at a time, so reads and writes to the same entry
// never overlap and no forwarding is needed.
//
// Reset clears the fill count, the sequencer and the output valid; the memory
// contents are not cleared since only written entries are ever read. When the
// receiver stalls, the finished result holds in the output register, a new
// item may still be accepted, and its result waits until the register frees.
module lifo_stack_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lifo_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lifo_pkg::out_item_t out_item
);

  // Sequencer states: idle waits for an item, read waits for the registered
  // memory word of a pop or peek, dump read does the same for a dump entry,
  // and emit hands the pending result to the output register.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_DRD,
    S_EMIT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [lifo_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [lifo_pkg::ADDR_W-1:0]      idx_r, idx_nxt;
  logic                             dump_r, dump_nxt;
  lifo_pkg::out_item_t              res_r, res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  lifo_pkg::out_item_t              out_item_r, out_item_nxt;

  // Stack memory and its ports.
  logic signed [lifo_pkg::WORD_W-1:0] mem [lifo_pkg::DEPTH];
  logic signed [lifo_pkg::WORD_W-1:0] rd_q;
  logic                               mem_we;
  logic [lifo_pkg::ADDR_W-1:0]        mem_waddr;
  logic signed [lifo_pkg::WORD_W-1:0] mem_wdata;
  logic                               mem_re;
  logic [lifo_pkg::ADDR_W-1:0]        mem_raddr;

  // Helpers for the fill count and change position checks.
  logic                             full;
  logic                             empty;
  logic [lifo_pkg::CNT_W-1:0]       cnt_inc;
  logic [lifo_pkg::CNT_W-1:0]       cnt_dec;
  logic [lifo_pkg::CMP_W-1:0]       pos_e;
  logic [lifo_pkg::CMP_W-1:0]       cnt_e;
  logic [lifo_pkg::CMP_W-1:0]       chg_addr;
  logic                             pos_bad;
  logic [lifo_pkg::ADDR_W-1:0]      idx_inc;
  logic                             dump_last;

  function automatic logic [lifo_pkg::COUNT_W-1:0] to_count(
    input logic [lifo_pkg::CNT_W-1:0] c
  );
    logic [lifo_pkg::CMP_W-1:0] e;
    e = lifo_pkg::CMP_W'(c);
    return e[lifo_pkg::COUNT_W-1:0];
  endfunction

  function automatic lifo_pkg::out_item_t make_res(
    input logic [lifo_pkg::STATUS_W-1:0]     status,
    input logic signed [lifo_pkg::WORD_W-1:0] data,
    input logic [lifo_pkg::CNT_W-1:0]        count,
    input logic                              last
  );
    lifo_pkg::out_item_t r;
    r.status = status;
    r.data   = data;
    r.count  = to_count(count);
    r.last   = last;
    return r;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign full      = (cnt_r == lifo_pkg::CNT_W'(lifo_pkg::DEPTH));
  assign empty     = (cnt_r == '0);
  assign cnt_inc   = cnt_r + lifo_pkg::CNT_W'(1);
  assign cnt_dec   = cnt_r - lifo_pkg::CNT_W'(1);
  assign pos_e     = lifo_pkg::CMP_W'(in_item.position);
  assign cnt_e     = lifo_pkg::CMP_W'(cnt_r);
  assign chg_addr  = cnt_e - pos_e;
  assign pos_bad   = (pos_e == '0) || (pos_e > cnt_e);
  assign idx_inc   = idx_r + lifo_pkg::ADDR_W'(1);
  assign dump_last = ((lifo_pkg::CNT_W'(idx_r) + lifo_pkg::CNT_W'(1)) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    dump_nxt      = dump_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = in_item.value;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dump_nxt = 1'b0;
          case (in_item.op)
            lifo_pkg::OP_PUSH: begin
              state_nxt = S_EMIT;
              if (full) begin
                res_nxt = make_res(lifo_pkg::ST_OVER, '0, cnt_r, 1'b1);
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[lifo_pkg::ADDR_W-1:0];
                cnt_nxt   = cnt_inc;
                res_nxt   = make_res(lifo_pkg::ST_OK, '0, cnt_inc, 1'b1);
              end
            end
            lifo_pkg::OP_POP: begin
              if (empty) begin
                res_nxt   = make_res(lifo_pkg::ST_EMPTY, '0, cnt_r, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_dec[lifo_pkg::ADDR_W-1:0];
                cnt_nxt   = cnt_dec;
                res_nxt   = make_res(lifo_pkg::ST_OK, '0, cnt_dec, 1'b1);
                state_nxt = S_RD;
              end
            end
            lifo_pkg::OP_PEEK: begin
              if (empty) begin
                res_nxt   = make_res(lifo_pkg::ST_EMPTY, '0, cnt_r, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_dec[lifo_pkg::ADDR_W-1:0];
                res_nxt   = make_res(lifo_pkg::ST_OK, '0, cnt_r, 1'b1);
                state_nxt = S_RD;
              end
            end
            lifo_pkg::OP_CHANGE: begin
              state_nxt = S_EMIT;
              if (empty) begin
                res_nxt = make_res(lifo_pkg::ST_EMPTY, '0, cnt_r, 1'b1);
              end else if (pos_bad) begin
                res_nxt = make_res(lifo_pkg::ST_BADPOS, '0, cnt_r, 1'b1);
              end else begin
                mem_we    = 1'b1;
                mem_waddr = chg_addr[lifo_pkg::ADDR_W-1:0];
                res_nxt   = make_res(lifo_pkg::ST_OK, '0, cnt_r, 1'b1);
              end
            end
            lifo_pkg::OP_DUMP: begin
              if (empty) begin
                res_nxt   = make_res(lifo_pkg::ST_EMPTY, '0, cnt_r, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                idx_nxt   = '0;
                dump_nxt  = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_nxt = S_DRD;
              end
            end
            default: begin
              // Undefined operation: dropped with no result.
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt.data = rd_q;
        state_nxt    = S_EMIT;
      end
      S_DRD: begin
        res_nxt   = make_res(lifo_pkg::ST_OK, rd_q, cnt_r, dump_last);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          if (dump_r && !res_r.last) begin
            // Fetch the next entry up while this one leaves.
            idx_nxt   = idx_inc;
            mem_re    = 1'b1;
            mem_raddr = idx_inc;
            state_nxt = S_DRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      dump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      dump_r      <= dump_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lifo_pkg::CNT_W'(lifo_pkg::DEPTH))
    else $error("fill count exceeds depth");

  // The fill count only moves as a consequence of an accepted item.
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=> $stable(cnt_r))
    else $error("fill count changed without an accepted item");

  // Only dump entries below the top go out without the last flag, always ok.
  a_notlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> (out_item.status == lifo_pkg::ST_OK))
    else $error("non-final result with error status");

  // A pop on a non-empty stack lowers the count by exactly one.
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_item.op == lifo_pkg::OP_POP) && !empty)
      |=> (cnt_r == $past(cnt_r) - lifo_pkg::CNT_W'(1)))
    else $error("pop did not decrement the fill count");
`endif

endmodule
